// File: src/hsmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash set membership table package
// Shared constants, operation codes, channel word types and the control
// interface between the controller and the datapath.
// ----------------------------------------------------------------------------
package hsmt_pkg;

    localparam int KEY_BITS        = 20;
    localparam int OPCODE_W        = 2;
    localparam int NUM_BUCKETS_DEF = 1009;
    localparam int BUCKET_WAYS_DEF = 4;
    localparam int DIV_STEP_BITS   = 4;
    localparam int DIV_STEPS       = KEY_BITS / DIV_STEP_BITS;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

    localparam logic [OPCODE_W-1:0] OP_ADD      = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CONTAINS = 2'd2;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KEY_BITS-1:0] key;
    } cmd_word_t;

    typedef struct packed {
        logic was_present;
        logic status;
    } result_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_LOOKUP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic clr_wr;
        logic mem_rd;
        logic update;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic clr_last;
    } dp_status_t;

endpackage

// File: src/hsmt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash set membership table datapath
// Bucket index reduction, bucket row memory with its clearing sweep, way
// compare and update logic, and the result word register.
// ----------------------------------------------------------------------------
module hsmt_datapath #(
    parameter int NUM_BUCKETS = hsmt_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_WAYS = hsmt_pkg::BUCKET_WAYS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hsmt_pkg::ctl_cmd_t   ctl,
    output hsmt_pkg::dp_status_t sts,
    input  hsmt_pkg::cmd_word_t  cmd,
    output hsmt_pkg::result_word_t result
);
    import hsmt_pkg::*;

    localparam int AW    = $clog2(NUM_BUCKETS);
    localparam int RB    = AW + 1;
    localparam int ROW_W = BUCKET_WAYS * (KEY_BITS + 1);
    localparam logic [RB-1:0] NB = RB'(NUM_BUCKETS);
    localparam logic [AW-1:0] LAST_ROW = AW'(NUM_BUCKETS - 1);

    logic [ROW_W-1:0]    mem [NUM_BUCKETS];
    logic [ROW_W-1:0]    rd_row_reg;

    logic [KEY_BITS-1:0] key_reg;
    logic [OPCODE_W-1:0] op_reg;
    logic [KEY_BITS-1:0] div_reg;
    logic [KEY_BITS-1:0] div_next;
    logic [AW-1:0]       rem_reg;
    logic [AW-1:0]       rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic                res_present_reg;
    logic                res_status_reg;
    result_word_t        out_reg;

    logic [BUCKET_WAYS-1:0]               rd_valid;
    logic [BUCKET_WAYS-1:0][KEY_BITS-1:0] rd_keys;
    logic [BUCKET_WAYS-1:0]               hit;
    logic [BUCKET_WAYS-1:0]               free_oh;
    logic [BUCKET_WAYS-1:0]               new_valid;
    logic [BUCKET_WAYS-1:0][KEY_BITS-1:0] new_keys;
    logic                                 present;
    logic                                 full;
    logic                                 dropped;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ROW_W-1:0] wr_row;

    // The bucket index is built four key bits per cycle by restoring reduction.
    always_comb
    begin
        logic [RB-1:0] t;
        logic [AW-1:0] r;
        r = rem_reg;
        t = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            t = {r, div_reg[KEY_BITS-1-i]};
            if (t >= NB)
            begin
                t = t - NB;
            end
            r = t[AW-1:0];
        end
        rem_next = r;
        div_next = div_reg << DIV_STEP_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg  <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                div_cnt_reg <= '0;
            end
            else if (ctl.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (ctl.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg <= cmd.key;
            op_reg  <= cmd.opcode;
            div_reg <= cmd.key;
            rem_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            div_reg <= div_next;
            rem_reg <= rem_next;
        end
        if (ctl.update)
        begin
            res_present_reg <= present;
            res_status_reg  <= dropped ? STATUS_DROPPED : STATUS_DONE;
        end
        if (ctl.out_load)
        begin
            out_reg.was_present <= res_present_reg;
            out_reg.status      <= res_status_reg;
        end
    end

    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.clr_last = (clr_addr_reg == LAST_ROW);

    always_comb
    begin
        rd_valid = rd_row_reg[BUCKET_WAYS-1:0];
        rd_keys  = rd_row_reg[ROW_W-1:BUCKET_WAYS];
        for (int w = 0; w < BUCKET_WAYS; w++)
        begin
            hit[w] = rd_valid[w] && (rd_keys[w] == key_reg);
        end
        present   = |hit;
        full      = &rd_valid;
        free_oh   = ~rd_valid & (rd_valid + BUCKET_WAYS'(1));
        new_valid = rd_valid;
        new_keys  = rd_keys;
        dropped   = 1'b0;
        case (op_reg)
            OP_ADD:
            begin
                if (!present)
                begin
                    if (full)
                    begin
                        dropped = 1'b1;
                    end
                    else
                    begin
                        new_valid = rd_valid | free_oh;
                        for (int w = 0; w < BUCKET_WAYS; w++)
                        begin
                            if (free_oh[w])
                            begin
                                new_keys[w] = key_reg;
                            end
                        end
                    end
                end
            end
            OP_REMOVE:
            begin
                new_valid = rd_valid & ~hit;
            end
            default:
            begin
                new_valid = rd_valid;
            end
        endcase
    end

    assign wr_en   = ctl.clr_wr | ctl.update;
    assign wr_addr = ctl.clr_wr ? clr_addr_reg : rem_reg;
    assign wr_row  = ctl.clr_wr ? '0 : {new_keys, new_valid};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mem_rd)
        begin
            rd_row_reg <= mem[rem_reg];
        end
    end

    assign result = out_reg;

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update |-> $onehot0(hit))
        else $error("More than one way of a bucket holds the same key.");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mem_rd |-> ({1'b0, rem_reg} < NB))
        else $error("Bucket index is not below the bucket count.");

endmodule

// File: src/hsmt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash set membership table controller
// Sequences the clearing sweep and each operation through index reduction,
// row read, lookup and write back, and result delivery.
// ----------------------------------------------------------------------------
module hsmt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    output hsmt_pkg::ctl_cmd_t   ctl,
    input  hsmt_pkg::dp_status_t sts
);
    import hsmt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        cmd_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
            end
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                ctl.load  = cmd_valid;
            end
            ST_DIVIDE:
            begin
                ctl.div_step = 1'b1;
            end
            ST_READ:
            begin
                ctl.mem_rd = 1'b1;
            end
            ST_LOOKUP:
            begin
                ctl.update = 1'b1;
            end
            ST_FINISH:
            begin
                ctl.out_load = out_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    assign out_valid_next = ctl.out_load || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("A second word was taken while an operation is in progress.");

    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || !result_stall))
        else $error("A result overwrote a word that was still waiting.");

    a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!out_valid_reg && cmd_stall))
        else $error("Channel activity during the clearing sweep.");

endmodule

// File: src/hash_set_membership_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash set membership table
// Operations are handled singly: a command word is taken only in the idle state,
// after the previous result has been loaded into the result register, and each is
// paced by the index reduction that folds four key bits into the bucket index per cycle.
// Reset: a clearing sweep writes every bucket row (NUM_BUCKETS rows, 1009 by
// default) with cmd_stall high; then commands are taken.
// ----------------------------------------------------------------------------
module hash_set_membership_table #(
    parameter int NUM_BUCKETS = hsmt_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_WAYS = hsmt_pkg::BUCKET_WAYS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  hsmt_pkg::cmd_word_t    cmd,
    output logic                   result_valid,
    input  logic                   result_stall,
    output hsmt_pkg::result_word_t result
);
    import hsmt_pkg::*;

    ctl_cmd_t   ctl;
    dp_status_t sts;

    hsmt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctl          (ctl),
        .sts          (sts)
    );

    hsmt_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sts    (sts),
        .cmd    (cmd),
        .result (result)
    );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash set membership table testbench
// Walks a table of directed command words, then a long random run that is
// biased toward a few crowded buckets so that they fill, overflow and drain.
// A bucketed shadow set predicts the results the directed table leaves open;
// results are checked in order. Both channels idle at random, and the receiver
// holds off once for a long stretch so the block backs up to the command side.
// ----------------------------------------------------------------------------
module tb_top;

    import hsmt_pkg::*;

    localparam int NUM_BUCKETS  = NUM_BUCKETS_DEF;
    localparam int WAYS         = BUCKET_WAYS_DEF;
    localparam int RANDOM_WORDS = 1425;
    localparam int HOT_COUNT    = 8;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_FROM   = 700;
    localparam int QUIET_TO     = 900;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int REPORT_MAX   = 10;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        cmd_word_t    word;
        logic         typed;
        result_word_t exp;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        {OP_CONTAINS, 20'd0,       1'b1, 1'b0, STATUS_DONE},
        {OP_ADD,      20'd0,       1'b1, 1'b0, STATUS_DONE},
        {OP_ADD,      20'd0,       1'b1, 1'b1, STATUS_DONE},
        {OP_CONTAINS, 20'd0,       1'b1, 1'b1, STATUS_DONE},
        {OP_ADD,      20'd5,       1'b1, 1'b0, STATUS_DONE},
        {OP_ADD,      20'd1014,    1'b1, 1'b0, STATUS_DONE},
        {OP_ADD,      20'd2023,    1'b1, 1'b0, STATUS_DONE},
        {OP_ADD,      20'd3032,    1'b1, 1'b0, STATUS_DONE},
        {OP_ADD,      20'd4041,    1'b1, 1'b0, STATUS_DROPPED},
        {OP_CONTAINS, 20'd4041,    1'b1, 1'b0, STATUS_DONE},
        {OP_REMOVE,   20'd1014,    1'b1, 1'b1, STATUS_DONE},
        {OP_REMOVE,   20'd1014,    1'b1, 1'b0, STATUS_DONE},
        {OP_ADD,      20'd4041,    1'b1, 1'b0, STATUS_DONE},
        {OP_CONTAINS, 20'd4041,    1'b1, 1'b1, STATUS_DONE},
        {OP_ADD,      20'd5050,    1'b1, 1'b0, STATUS_DROPPED},
        {OP_UNUSED,   20'd5,       1'b1, 1'b1, STATUS_DONE},
        {OP_UNUSED,   20'd1014,    1'b1, 1'b0, STATUS_DONE},
        {OP_ADD,      20'hFFFFF,   1'b1, 1'b0, STATUS_DONE},
        {OP_CONTAINS, 20'hFFFFF,   1'b1, 1'b1, STATUS_DONE},
        {OP_REMOVE,   20'hFFFFF,   1'b1, 1'b1, STATUS_DONE},
        {OP_REMOVE,   20'd0,       1'b1, 1'b1, STATUS_DONE},
        {OP_ADD,      20'h55555,   1'b0, 1'b0, STATUS_DONE},
        {OP_ADD,      20'hAAAAA,   1'b0, 1'b0, STATUS_DONE},
        {OP_CONTAINS, 20'h55555,   1'b0, 1'b0, STATUS_DONE}
    };

    logic         clk;
    logic         rst_n;
    logic         cmd_valid;
    logic         cmd_stall;
    cmd_word_t    cmd;
    logic         result_valid;
    logic         result_stall;
    result_word_t result;

    logic [KEY_BITS-1:0] set_keys  [NUM_BUCKETS][WAYS];
    logic [WAYS-1:0]     set_valid [NUM_BUCKETS];
    result_word_t        expected_results [$];
    int                  hot_buckets [HOT_COUNT];

    int n_accepted;
    int n_results;
    int n_failures;
    int n_adds;
    int n_removes;
    int n_queries;
    int n_hits;
    int n_dropped;
    bit quiet;

    hash_set_membership_table u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d words accepted", n_accepted);
        $display("Regression FAIL");
        $finish;
    end

    assign quiet = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);

    function automatic result_word_t apply_set_op(cmd_word_t w);
        result_word_t r;
        int bkt;
        int hit;
        int free_way;
        int i;
        bkt = int'(w.key % NUM_BUCKETS);
        hit = -1;
        free_way = -1;
        for (i = 0; i < WAYS; i++)
        begin
            if (set_valid[bkt][i] && set_keys[bkt][i] == w.key && hit < 0)
                hit = i;
            if (!set_valid[bkt][i] && free_way < 0)
                free_way = i;
        end
        r.was_present = (hit >= 0);
        r.status = STATUS_DONE;
        if (hit >= 0)
            n_hits++;
        if (w.opcode == OP_ADD)
        begin
            n_adds++;
            if (hit < 0 && free_way >= 0)
            begin
                set_keys[bkt][free_way] = w.key;
                set_valid[bkt][free_way] = 1'b1;
            end
            else if (hit < 0)
            begin
                r.status = STATUS_DROPPED;
                n_dropped++;
            end
        end
        else if (w.opcode == OP_REMOVE)
        begin
            n_removes++;
            if (hit >= 0)
                set_valid[bkt][hit] = 1'b0;
        end
        else
        begin
            n_queries++;
        end
        return r;
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45)
            w.opcode = OP_ADD;
        else if (roll < 70)
            w.opcode = OP_REMOVE;
        else if (roll < 95)
            w.opcode = OP_CONTAINS;
        else
            w.opcode = OP_UNUSED;
        if ($urandom_range(99) < 75)
            w.key = KEY_BITS'(hot_buckets[$urandom_range(HOT_COUNT - 1)]
                              + NUM_BUCKETS * $urandom_range(7));
        else
            w.key = KEY_BITS'($urandom);
        return w;
    endfunction

    task automatic note_failure(input string what);
        n_failures++;
        if (n_failures <= REPORT_MAX)
            $display("Mismatch %0d: %s", n_failures, what);
    endtask

    task automatic send_word(input cmd_word_t w, input logic typed, input result_word_t exp);
        result_word_t predicted;
        while (!quiet && $urandom_range(99) < 13)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        predicted = apply_set_op(w);
        expected_results.insert(expected_results.size(), typed ? exp : predicted);
        n_accepted++;
    endtask

    initial
    begin
        int i;
        int waited;
        for (i = 0; i < NUM_BUCKETS; i++)
            set_valid[i] = '0;
        hot_buckets[0] = 0;
        hot_buckets[1] = NUM_BUCKETS - 1;
        for (i = 2; i < HOT_COUNT; i++)
            hot_buckets[i] = $urandom_range(NUM_BUCKETS - 1);
        n_accepted = 0;
        n_results = 0;
        n_failures = 0;
        n_adds = 0;
        n_removes = 0;
        n_queries = 0;
        n_hits = 0;
        n_dropped = 0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].exp);
        for (i = 0; i < RANDOM_WORDS; i++)
            send_word(random_word(), 1'b0, '0);
        cmd_valid <= 1'b0;

        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        while (expected_results.size() != 0)
        begin
            void'(expected_results.pop_front());
            note_failure("result word never arrived");
        end

        $display("Ran %0d words: %0d adds, %0d removes, %0d queries.",
                 n_accepted, n_adds, n_removes, n_queries);
        $display("Keys found present %0d times, adds dropped on full buckets %0d times.",
                 n_hits, n_dropped);
        if (n_failures == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("%0d mismatches in total", n_failures);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (!hold_done && n_accepted >= HOLD_AT)
            begin
                result_stall <= 1'b1;
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
            end
            else
            begin
                result_stall <= !quiet && ($urandom_range(99) < 13);
            end
        end
    end

    initial
    begin
        result_word_t exp;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    note_failure($sformatf("unexpected result word %b/%b",
                                           result.was_present, result.status));
                end
                else
                begin
                    exp = expected_results.pop_front();
                    if (result.was_present !== exp.was_present || result.status !== exp.status)
                        note_failure($sformatf(
                            "result %0d: expected was_present %b status %b, got %b %b",
                            n_results, exp.was_present, exp.status,
                            result.was_present, result.status));
                end
            end
        end
    end

endmodule

// File: filelist.f
src/hsmt_pkg.sv
src/hsmt_datapath.sv
src/hsmt_ctrl.sv
src/hash_set_membership_table.sv
sim/tb_top.sv
